FILE: src/rmw_pkg.sv
`default_nettype none

package rmw_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS      = 16;
  localparam int QUOT_BITS      = 33;
  localparam int ROOT_BITS      = 17;
  localparam int CFG_ADDR_BITS  = 5;
  localparam int CFG_DATA_BITS  = 32;

  typedef enum logic [2:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_WARP_RADIUS  = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4
  } reg_idx_t;

endpackage

`default_nettype wire

FILE: src/radial_magnify_warp_address.sv
// Throughput: one word per cycle; the pipeline advances as one and holds when
// the output word is stalled.
// The ratio r/sqrt(d2) is set by a 33-stage divider and a 17-stage root pipe.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// configuration registers to their defaults.
`default_nettype none

module radial_magnify_warp_address #(
  parameter int COORD_BITS = rmw_pkg::COORD_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // dest_x, dest_y
  input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // src_x, src_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0]          out_tdata,
  // in_region
  output logic                                       out_tuser,
  input  wire logic                                  cfg_psel,
  input  wire logic                                  cfg_penable,
  input  wire logic                                  cfg_pwrite,
  input  wire logic [rmw_pkg::CFG_ADDR_BITS-1:0]     cfg_paddr,
  input  wire logic [rmw_pkg::CFG_DATA_BITS-1:0]     cfg_pwdata,
  output logic [rmw_pkg::CFG_DATA_BITS-1:0]          cfg_prdata,
  output logic                                       cfg_pready
);

  localparam int C      = COORD_BITS;
  localparam int DW     = C + 1;
  localparam int D2W    = 2 * C + 1;
  localparam int RW     = 2 * C + 2;
  localparam int QW     = rmw_pkg::QUOT_BITS;
  localparam int RTW    = rmw_pkg::ROOT_BITS;
  localparam int QPW    = 2 * RTW;
  localparam int SRW    = RTW + 4;
  localparam int FB     = rmw_pkg::FRAC_BITS;
  localparam int PW     = C + RTW;
  localparam int AW     = C + 18;
  localparam int TW     = C + 21;
  localparam int TTW    = TW - FB;
  localparam int IOW    = ((2 * C + 7) / 8) * 8;
  localparam int DIV0   = 4;
  localparam int SQ0    = DIV0 + QW;
  localparam int MULS   = SQ0 + RTW;
  localparam int SUMS   = MULS + 1;
  localparam int NSTG   = SUMS + 2;
  localparam int LAST   = NSTG - 1;

  typedef struct packed {
    logic [C-1:0] x;
    logic [C-1:0] y;
    logic [C-1:0] magx;
    logic [C-1:0] magy;
    logic         negx;
    logic         negy;
    logic         bnd;
    logic         region;
    logic         inner;
  } item_t;

  logic [C-1:0] center_x_r, center_y_r, warp_radius_r;
  logic [C:0]   image_width_r, image_height_r;
  logic         cfg_wr;
  rmw_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = rmw_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r     <= '0;
      center_y_r     <= '0;
      warp_radius_r  <= '0;
      image_width_r  <= (C+1)'(1) << C;
      image_height_r <= (C+1)'(1) << C;
    end else if (cfg_wr) begin
      case (cfg_idx)
        rmw_pkg::REG_CENTER_X:     center_x_r     <= cfg_pwdata[C-1:0];
        rmw_pkg::REG_CENTER_Y:     center_y_r     <= cfg_pwdata[C-1:0];
        rmw_pkg::REG_WARP_RADIUS:  warp_radius_r  <= cfg_pwdata[C-1:0];
        rmw_pkg::REG_IMAGE_WIDTH:  image_width_r  <= cfg_pwdata[C:0];
        rmw_pkg::REG_IMAGE_HEIGHT: image_height_r <= cfg_pwdata[C:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      rmw_pkg::REG_CENTER_X:     cfg_prdata = 32'(center_x_r);
      rmw_pkg::REG_CENTER_Y:     cfg_prdata = 32'(center_y_r);
      rmw_pkg::REG_WARP_RADIUS:  cfg_prdata = 32'(warp_radius_r);
      rmw_pkg::REG_IMAGE_WIDTH:  cfg_prdata = 32'(image_width_r);
      rmw_pkg::REG_IMAGE_HEIGHT: cfg_prdata = 32'(image_height_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  logic  vld_r [NSTG];
  item_t pl_r  [NSTG];
  logic  adv;

  assign adv       = !vld_r[LAST] || out_tready;
  assign in_tready = adv;

  // Stage 0: offsets from the center and the rectangular bounds.
  logic [C-1:0] in_x, in_y, xlo, ylo;
  logic [C:0]   xsum, ysum, xhi, yhi;
  logic [DW-1:0] dxs, dys, ndx, ndy;
  item_t st0_nxt;

  always_comb begin
    in_x = in_tdata[C-1:0];
    in_y = in_tdata[2*C-1:C];
    xlo  = (center_x_r >= warp_radius_r) ? center_x_r - warp_radius_r : '0;
    ylo  = (center_y_r >= warp_radius_r) ? center_y_r - warp_radius_r : '0;
    xsum = {1'b0, center_x_r} + {1'b0, warp_radius_r};
    ysum = {1'b0, center_y_r} + {1'b0, warp_radius_r};
    xhi  = (xsum < image_width_r)  ? xsum : image_width_r;
    yhi  = (ysum < image_height_r) ? ysum : image_height_r;
    dxs  = {1'b0, in_x} - {1'b0, center_x_r};
    dys  = {1'b0, in_y} - {1'b0, center_y_r};
    ndx  = -dxs;
    ndy  = -dys;
    st0_nxt.x      = in_x;
    st0_nxt.y      = in_y;
    st0_nxt.negx   = dxs[DW-1];
    st0_nxt.negy   = dys[DW-1];
    st0_nxt.magx   = dxs[DW-1] ? ndx[C-1:0] : dxs[C-1:0];
    st0_nxt.magy   = dys[DW-1] ? ndy[C-1:0] : dys[C-1:0];
    st0_nxt.bnd    = (in_x >= xlo) && ({1'b0, in_x} < xhi) &&
                     (in_y >= ylo) && ({1'b0, in_y} < yhi);
    st0_nxt.region = 1'b0;
    st0_nxt.inner  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pl_r[0] <= st0_nxt;
    end
  end

  // Stages 1 to 3: squares, distance and zone tests.
  logic [2*C-1:0] sqx_r, sqy_r, r2_1_r, r2_2_r, r2_3_r;
  logic [D2W-1:0] d2_2_r, d2_3_r;
  logic [D2W+4:0] lhs25, rhs16;
  item_t st3_nxt;

  always_comb begin
    lhs25 = (D2W+5)'(d2_2_r) + (D2W+5)'({d2_2_r, 3'b000}) + (D2W+5)'({d2_2_r, 4'b0000});
    rhs16 = (D2W+5)'({r2_2_r, 4'b0000});
    st3_nxt        = pl_r[2];
    st3_nxt.region = pl_r[2].bnd && ((2*C+2)'(d2_2_r) <= (2*C+2)'(r2_2_r));
    st3_nxt.inner  = lhs25 <= rhs16;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqx_r  <= pl_r[0].magx * pl_r[0].magx;
      sqy_r  <= pl_r[0].magy * pl_r[0].magy;
      r2_1_r <= warp_radius_r * warp_radius_r;
      d2_2_r <= D2W'(sqx_r) + D2W'(sqy_r);
      r2_2_r <= r2_1_r;
      d2_3_r <= d2_2_r;
      r2_3_r <= r2_2_r;
    end
  end

  // Stages DIV0 to DIV0+QW-1: floor(r2 * 2^32 / d2), one quotient bit each.
  logic [RW-1:0]  drem_r [QW];
  logic [D2W-1:0] dden_r [QW];
  logic [QW-1:0]  dquo_r [QW];

  // Stages SQ0 to SQ0+RTW-1: integer square root, one root bit each.
  logic [SRW-1:0] srem_r [RTW];
  logic [RTW-1:0] sroot_r [RTW];
  logic [QPW-1:0] ssrc_r [RTW];

  genvar gi;
  generate
    for (gi = 1; gi < NSTG; gi++) begin : g_ctl
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[gi] <= 1'b0;
        end else if (adv) begin
          vld_r[gi] <= vld_r[gi-1];
        end
      end
      if (gi == 3) begin : g_flag
        always_ff @(posedge clk) begin
          if (adv) begin
            pl_r[gi] <= st3_nxt;
          end
        end
      end else begin : g_copy
        always_ff @(posedge clk) begin
          if (adv) begin
            pl_r[gi] <= pl_r[gi-1];
          end
        end
      end
    end

    for (gi = 0; gi < QW; gi++) begin : g_div
      logic [RW-1:0]  rin;
      logic [D2W-1:0] den;
      logic [QW-1:0]  qin;
      logic           ge;
      if (gi == 0) begin : g_first
        assign rin = RW'(r2_3_r);
        assign den = d2_3_r;
        assign qin = '0;
      end else begin : g_next
        assign rin = {drem_r[gi-1][RW-2:0], 1'b0};
        assign den = dden_r[gi-1];
        assign qin = dquo_r[gi-1];
      end
      assign ge = rin >= RW'(den);
      always_ff @(posedge clk) begin
        if (adv) begin
          drem_r[gi] <= ge ? rin - RW'(den) : rin;
          dden_r[gi] <= den;
          dquo_r[gi] <= {qin[QW-2:0], ge};
        end
      end
    end

    for (gi = 0; gi < RTW; gi++) begin : g_sqrt
      logic [SRW-1:0] rprev, cur, trial;
      logic [RTW-1:0] root;
      logic [QPW-1:0] src;
      logic           ge;
      if (gi == 0) begin : g_first
        assign rprev = '0;
        assign root  = '0;
        assign src   = QPW'(dquo_r[QW-1]);
      end else begin : g_next
        assign rprev = srem_r[gi-1];
        assign root  = sroot_r[gi-1];
        assign src   = ssrc_r[gi-1];
      end
      assign cur   = {rprev[SRW-3:0], src[QPW-1:QPW-2]};
      assign trial = SRW'({root, 2'b01});
      assign ge    = cur >= trial;
      always_ff @(posedge clk) begin
        if (adv) begin
          srem_r[gi]  <= ge ? cur - trial : cur;
          sroot_r[gi] <= {root[RTW-2:0], ge};
          ssrc_r[gi]  <= {src[QPW-3:0], 2'b00};
        end
      end
    end
  endgenerate

  // Product of offset magnitude and ratio.
  logic [PW-1:0] px_r, py_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= PW'(pl_r[MULS-1].magx) * PW'(sroot_r[RTW-1]);
      py_r <= PW'(pl_r[MULS-1].magy) * PW'(sroot_r[RTW-1]);
    end
  end

  function automatic logic signed [TTW-1:0] map_coord(
    input logic [C-1:0]  c,
    input logic [C-1:0]  mag,
    input logic          neg,
    input logic          inner,
    input logic [PW-1:0] p
  );
    logic [AW-1:0]        m, a, am;
    logic signed [TW-1:0] t, tb;
    begin
      m  = AW'((AW'(p) + AW'({p, 1'b0})) >> 1);
      am = AW'({mag, 17'd0}) + AW'({mag, 15'd0});
      a  = inner ? AW'({mag, 15'd0}) + AW'({mag, 13'd0}) : am - m;
      t  = $signed(TW'({c, 16'd0}));
      t  = neg ? t - $signed(TW'(a)) : t + $signed(TW'(a));
      tb = (t < 0) ? t + $signed(TW'(17'h0FFFF)) : t;
      map_coord = TTW'(tb >>> FB);
    end
  endfunction

  logic signed [TTW-1:0] tx_r, ty_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      tx_r <= map_coord(center_x_r, pl_r[SUMS-1].magx, pl_r[SUMS-1].negx,
                        pl_r[SUMS-1].inner, px_r);
      ty_r <= map_coord(center_y_r, pl_r[SUMS-1].magy, pl_r[SUMS-1].negy,
                        pl_r[SUMS-1].inner, py_r);
    end
  end

  function automatic logic [C-1:0] clamp_coord(
    input logic signed [TTW-1:0] v,
    input logic [C:0]            dim
  );
    logic [C:0] lim, limm1;
    begin
      lim   = (dim > ((C+1)'(1) << C)) ? ((C+1)'(1) << C) : dim;
      limm1 = lim - (C+1)'(1);
      if (lim == '0 || v < 0) begin
        clamp_coord = '0;
      end else if (v > $signed(TTW'(limm1))) begin
        clamp_coord = limm1[C-1:0];
      end else begin
        clamp_coord = v[C-1:0];
      end
    end
  endfunction

  logic [C-1:0] srcx_r, srcy_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      srcx_r <= pl_r[LAST-1].region ? clamp_coord(tx_r, image_width_r)  : pl_r[LAST-1].x;
      srcy_r <= pl_r[LAST-1].region ? clamp_coord(ty_r, image_height_r) : pl_r[LAST-1].y;
    end
  end

  assign out_tvalid = vld_r[LAST];
  assign out_tuser  = pl_r[LAST].region;
  assign out_tdata  = IOW'({srcy_r, srcx_r});

endmodule

`default_nettype wire

FILE: src/rmw_checker.sv
`default_nettype none

module rmw_checker #(
  parameter int OUT_W = ((2 * rmw_pkg::COORD_BITS_DEF + 7) / 8) * 8
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata,
  input wire logic             out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output word changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input not ready while output is empty");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while pipeline is stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n ##1 !rst_n |-> !out_tvalid)
    else $error("output valid during reset");

endmodule

bind radial_magnify_warp_address rmw_checker u_rmw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
